// ===== rtl/core/ltlt_pkg.sv =====
package ltlt_pkg;

    localparam int OP_W     = 2;
    localparam int LIGHT_W  = 8;
    localparam int DELTA_W  = 16;
    localparam int STATUS_W = 2;
    localparam int LAT_W    = 22;
    localparam int CNT_W    = 20;
    localparam int AVG_W    = 30;
    localparam int FRAC_W   = 8;
    localparam int LEVEL_W  = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SUCCESS      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SYNC_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIME_TIMEOUT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_LATENCY = 2'd3;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_DARK    = 2'd1;
    localparam logic [1:0] REG_BRIGHT  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    localparam logic [LEVEL_W-1:0] DARK_RESET    = 8'd64;
    localparam logic [LEVEL_W-1:0] BRIGHT_RESET  = 8'd192;
    localparam logic [LAT_W-1:0]   TIMEOUT_RESET = 22'd2000000;

    localparam logic [LAT_W-1:0] LAT_MAX = {LAT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [LAT_W-1:0] last;
        logic [AVG_W-1:0] avg;
        logic [LAT_W-1:0] min;
        logic [LAT_W-1:0] max;
    } stats_t;

    localparam stats_t STATS_RESET = '{
        cnt:  '0,
        last: '0,
        avg:  '0,
        min:  LAT_MAX,
        max:  '0
    };

endpackage

// ===== rtl/core/ltlt_req_if.sv =====
interface ltlt_req_if;
    logic                         valid;
    logic                         ready;
    logic [ltlt_pkg::OP_W-1:0]    op;
    logic [ltlt_pkg::LIGHT_W-1:0] light;
    logic [ltlt_pkg::DELTA_W-1:0] delta_us;

    modport source (output valid, output op, output light, output delta_us, input ready);
    modport sink (input valid, input op, input light, input delta_us, output ready);
endinterface

// ===== rtl/core/ltlt_rsp_if.sv =====
interface ltlt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ltlt_pkg::STATUS_W-1:0] status;
    logic                          falling;
    logic [ltlt_pkg::LAT_W-1:0]    latency_us;
    logic [ltlt_pkg::CNT_W-1:0]    run_count;
    logic [ltlt_pkg::AVG_W-1:0]    avg_us_q8;
    logic [ltlt_pkg::LAT_W-1:0]    min_us;
    logic [ltlt_pkg::LAT_W-1:0]    max_us;

    modport source (output valid, output status, output falling, output latency_us,
                    output run_count, output avg_us_q8, output min_us, output max_us,
                    input ready);
    modport sink (input valid, input status, input falling, input latency_us,
                  input run_count, input avg_us_q8, input min_us, input max_us,
                  output ready);
endinterface

// ===== rtl/core/light_transition_latency_timer.sv =====
// Light transition latency timer.
// Requests arrive on req: op 0 arms a run, op 1 carries a light sample and the
// microseconds since the previous sample, op 2 clears both statistics sets.
// A finished run (success or failure) yields one response on rsp with the
// status, direction, latency and the statistics of that run's set.
// Thresholds, timeout and alternating mode are written through the APB port.
// A request that finishes no run leaves the block idle, ready for the next one.
// A failing or zero-latency run's last sample passes through accept, set read
// from the two-entry statistics memory, set select and response load. A
// successful run's last sample passes through accept, memory read, divider
// set-up, restoring division for the running average (one quotient bit per
// cycle), write back and response load.
// The response register parts both sides: a new request is taken while a
// response waits; when rsp stalls, the next response holds the block until
// the pending one is taken.
// Reset empties both statistics sets, clears the run state and the response
// valid flag, and loads the register defaults; no clearing pass is needed.
module light_transition_latency_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    ltlt_req_if.sink                      req,
    ltlt_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ltlt_pkg::ADDR_W-1:0]   paddr,
    input  logic [ltlt_pkg::DATA_W-1:0]   pwdata,
    output logic [ltlt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int DIV_STEPS = ltlt_pkg::AVG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_DIV,
        S_WB,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SYNC,
        PH_TIME
    } phase_t;

    state_t                          state_reg;
    phase_t                          phase_reg;
    logic                            mode_reg;
    logic [ltlt_pkg::LEVEL_W-1:0]    dark_reg;
    logic [ltlt_pkg::LEVEL_W-1:0]    bright_reg;
    logic [ltlt_pkg::LAT_W-1:0]      timeout_reg;
    logic                            measure_falling_reg;
    logic                            next_falling_reg;
    logic [ltlt_pkg::LAT_W-1:0]      elapsed_reg;
    logic [ltlt_pkg::LAT_W-1:0]      lat_reg;
    logic [ltlt_pkg::STATUS_W-1:0]   status_reg;
    logic [1:0]                      valid_reg;
    ltlt_pkg::stats_t                work_reg;
    ltlt_pkg::stats_t                rd_data_reg;
    logic [ltlt_pkg::AVG_W-1:0]      quo_reg;
    logic [ltlt_pkg::CNT_W:0]        rem_reg;
    logic                            pos_reg;
    logic [DIV_CNT_W-1:0]            div_cnt_reg;

    logic                            out_valid_reg;
    logic [ltlt_pkg::STATUS_W-1:0]   out_status_reg;
    logic                            out_falling_reg;
    logic [ltlt_pkg::LAT_W-1:0]      out_lat_reg;
    ltlt_pkg::stats_t                out_stats_reg;

    ltlt_pkg::stats_t                mem [2];

    logic                            accept;
    logic                            cfg_write;
    logic [ltlt_pkg::LAT_W:0]        sum;
    logic [ltlt_pkg::LAT_W-1:0]      elapsed_next;
    logic                            is_dark;
    logic                            is_bright;
    logic                            timed_out;
    ltlt_pkg::stats_t                entry;
    logic [ltlt_pkg::CNT_W-1:0]      cnt_next;
    logic [ltlt_pkg::AVG_W-1:0]      target;
    logic                            target_ge;
    logic [ltlt_pkg::CNT_W:0]        rem_shift;
    logic                            quo_bit;
    logic [ltlt_pkg::AVG_W-1:0]      avg_next;
    logic                            mem_we;
    ltlt_pkg::stats_t                mem_wdata;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            ltlt_pkg::REG_MODE:    prdata = ltlt_pkg::DATA_W'(mode_reg);
            ltlt_pkg::REG_DARK:    prdata = ltlt_pkg::DATA_W'(dark_reg);
            ltlt_pkg::REG_BRIGHT:  prdata = ltlt_pkg::DATA_W'(bright_reg);
            ltlt_pkg::REG_TIMEOUT: prdata = ltlt_pkg::DATA_W'(timeout_reg);
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        sum          = {1'b0, elapsed_reg} + (ltlt_pkg::LAT_W + 1)'(req.delta_us);
        elapsed_next = sum[ltlt_pkg::LAT_W] ? ltlt_pkg::LAT_MAX : sum[ltlt_pkg::LAT_W-1:0];
        is_dark      = (req.light <= dark_reg);
        is_bright    = (req.light >= bright_reg);
        timed_out    = (elapsed_next > timeout_reg);
    end

    always_comb
    begin
        entry     = valid_reg[measure_falling_reg] ? rd_data_reg : ltlt_pkg::STATS_RESET;
        cnt_next  = (entry.cnt != ltlt_pkg::CNT_MAX) ? entry.cnt + 1'b1 : entry.cnt;
        target    = {lat_reg, {ltlt_pkg::FRAC_W{1'b0}}};
        target_ge = (target >= entry.avg);
        rem_shift = {rem_reg[ltlt_pkg::CNT_W-1:0], quo_reg[ltlt_pkg::AVG_W-1]};
        quo_bit   = (rem_shift >= {1'b0, work_reg.cnt});
        avg_next  = pos_reg ? work_reg.avg + quo_reg : work_reg.avg - quo_reg;
        mem_we    = (state_reg == S_WB);
        mem_wdata = work_reg;
        mem_wdata.avg = avg_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[measure_falling_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[measure_falling_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            phase_reg           <= PH_IDLE;
            mode_reg            <= 1'b0;
            dark_reg            <= ltlt_pkg::DARK_RESET;
            bright_reg          <= ltlt_pkg::BRIGHT_RESET;
            timeout_reg         <= ltlt_pkg::TIMEOUT_RESET;
            measure_falling_reg <= 1'b0;
            next_falling_reg    <= 1'b0;
            elapsed_reg         <= '0;
            valid_reg           <= '0;
            div_cnt_reg         <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[3:2])
                    ltlt_pkg::REG_MODE:    mode_reg    <= pwdata[0];
                    ltlt_pkg::REG_DARK:    dark_reg    <= pwdata[ltlt_pkg::LEVEL_W-1:0];
                    ltlt_pkg::REG_BRIGHT:  bright_reg  <= pwdata[ltlt_pkg::LEVEL_W-1:0];
                    ltlt_pkg::REG_TIMEOUT: timeout_reg <= pwdata[ltlt_pkg::LAT_W-1:0];
                    default:               ;
                endcase
            end

            if (rsp.valid && rsp.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.op == ltlt_pkg::OP_START)
                        begin
                            measure_falling_reg <= mode_reg && next_falling_reg;
                            phase_reg           <= PH_SYNC;
                            elapsed_reg         <= '0;
                        end
                        else if (req.op == ltlt_pkg::OP_CLEAR)
                        begin
                            valid_reg        <= '0;
                            next_falling_reg <= 1'b0;
                            phase_reg        <= PH_IDLE;
                            elapsed_reg      <= '0;
                        end
                        else if (req.op == ltlt_pkg::OP_SAMPLE && phase_reg == PH_SYNC)
                        begin
                            if (measure_falling_reg ? is_bright : is_dark)
                            begin
                                phase_reg   <= PH_TIME;
                                elapsed_reg <= '0;
                            end
                            else if (timed_out)
                            begin
                                phase_reg  <= PH_IDLE;
                                status_reg <= ltlt_pkg::ST_SYNC_TIMEOUT;
                                lat_reg    <= '0;
                                state_reg  <= S_READ;
                            end
                            else
                            begin
                                elapsed_reg <= elapsed_next;
                            end
                        end
                        else if (req.op == ltlt_pkg::OP_SAMPLE && phase_reg == PH_TIME)
                        begin
                            if (measure_falling_reg ? is_dark : is_bright)
                            begin
                                phase_reg <= PH_IDLE;
                                lat_reg   <= elapsed_next;
                                status_reg <= (elapsed_next == '0) ?
                                              ltlt_pkg::ST_ZERO_LATENCY : ltlt_pkg::ST_SUCCESS;
                                state_reg <= S_READ;
                            end
                            else if (timed_out)
                            begin
                                phase_reg  <= PH_IDLE;
                                status_reg <= ltlt_pkg::ST_TIME_TIMEOUT;
                                lat_reg    <= '0;
                                state_reg  <= S_READ;
                            end
                            else
                            begin
                                elapsed_reg <= elapsed_next;
                            end
                        end
                    end
                end

                S_READ:
                begin
                    state_reg <= S_CALC;
                end

                S_CALC:
                begin
                    if (status_reg == ltlt_pkg::ST_SUCCESS)
                    begin
                        work_reg.cnt  <= cnt_next;
                        work_reg.last <= lat_reg;
                        work_reg.avg  <= entry.avg;
                        work_reg.min  <= (lat_reg < entry.min) ? lat_reg : entry.min;
                        work_reg.max  <= (lat_reg > entry.max) ? lat_reg : entry.max;
                        pos_reg       <= target_ge;
                        quo_reg       <= target_ge ? target - entry.avg : entry.avg - target;
                        rem_reg       <= '0;
                        div_cnt_reg   <= '0;
                        state_reg     <= S_DIV;
                    end
                    else
                    begin
                        work_reg  <= entry;
                        state_reg <= S_EMIT;
                    end
                end

                S_DIV:
                begin
                    rem_reg     <= quo_bit ? rem_shift - {1'b0, work_reg.cnt} : rem_shift;
                    quo_reg     <= {quo_reg[ltlt_pkg::AVG_W-2:0], quo_bit};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_WB;
                    end
                end

                S_WB:
                begin
                    work_reg.avg                   <= avg_next;
                    valid_reg[measure_falling_reg] <= 1'b1;
                    if (mode_reg)
                    begin
                        next_falling_reg <= !measure_falling_reg;
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= status_reg;
                        out_falling_reg <= measure_falling_reg;
                        out_lat_reg     <= (status_reg == ltlt_pkg::ST_SUCCESS) ? lat_reg : '0;
                        out_stats_reg   <= work_reg;
                        state_reg       <= S_IDLE;
                    end
                    else if (rsp.valid && rsp.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.falling    = out_falling_reg;
    assign rsp.latency_us = out_lat_reg;
    assign rsp.run_count  = out_stats_reg.cnt;
    assign rsp.avg_us_q8  = out_stats_reg.avg;
    assign rsp.min_us     = out_stats_reg.min;
    assign rsp.max_us     = out_stats_reg.max;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ltlt_pkg::*;

    localparam int      HALF_PERIOD  = 5;
    localparam longint  LIMIT_NS     = 10_000_000;
    localparam int      TARGET_ITEMS = 680;
    localparam int      PHASE_ITEMS  = 110;
    localparam int      DRAIN_CYCLES = 40;
    localparam int      LONG_HOLD    = 300;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {RUN_IDLE, RUN_SYNC, RUN_TIMING} run_phase_t;
    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {LIT_DARK, LIT_BRIGHT, LIT_NOT_DARK, LIT_NOT_BRIGHT} light_kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                falling;
        logic [LAT_W-1:0]    latency;
        logic [CNT_W-1:0]    count;
        logic [AVG_W-1:0]    avg;
        logic [LAT_W-1:0]    lo;
        logic [LAT_W-1:0]    hi;
    } timing_rsp_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [OP_W-1:0]    op;
        logic [LIGHT_W-1:0] light;
        logic [DELTA_W-1:0] delta;
        logic [1:0]         reg_idx;
        logic [DATA_W-1:0]  reg_val;
        logic               known;
        timing_rsp_t        want;
    } plan_row_t;

    localparam timing_rsp_t NO_RSP = '0;

    localparam plan_row_t PLAN [27] = '{
        '{ROW_REQ, OP_SAMPLE, 8'd255, 16'hFFFF, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_UNUSED, 8'hAA, 16'h5555, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_START, 8'h55, 16'hAAAA, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd64, 16'hFFFF, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd191, 16'd100, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd192, 16'd0, REG_MODE, 32'd0, 1'b1,
          '{ST_SUCCESS, 1'b0, 22'd100, 20'd1, 30'd25600, 22'd100, 22'd100}},
        '{ROW_REQ, OP_START, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd0, 16'd5, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd255, 16'd0, REG_MODE, 32'd0, 1'b1,
          '{ST_ZERO_LATENCY, 1'b0, 22'd0, 20'd1, 30'd25600, 22'd100, 22'd100}},
        '{ROW_REQ, OP_START, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_START, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_CLEAR, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_CFG, OP_START, 8'd0, 16'd0, REG_MODE, 32'd1, 1'b0, NO_RSP},
        '{ROW_CFG, OP_START, 8'd0, 16'd0, REG_TIMEOUT, 32'd0, 1'b0, NO_RSP},
        '{ROW_CFG, OP_START, 8'd0, 16'd0, REG_DARK, 32'd0, 1'b0, NO_RSP},
        '{ROW_CFG, OP_START, 8'd0, 16'd0, REG_BRIGHT, 32'd255, 1'b0, NO_RSP},
        '{ROW_REQ, OP_START, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd1, 16'd1, REG_MODE, 32'd0, 1'b1,
          '{ST_SYNC_TIMEOUT, 1'b0, 22'd0, 20'd0, 30'd0, LAT_MAX, 22'd0}},
        '{ROW_REQ, OP_START, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd0, 16'hFFFF, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd255, 16'hFFFF, REG_MODE, 32'd0, 1'b1,
          '{ST_SUCCESS, 1'b0, 22'd65535, 20'd1, 30'd16776960, 22'd65535, 22'd65535}},
        '{ROW_REQ, OP_START, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd255, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd128, 16'd1, REG_MODE, 32'd0, 1'b1,
          '{ST_TIME_TIMEOUT, 1'b1, 22'd0, 20'd0, 30'd0, LAT_MAX, 22'd0}},
        '{ROW_REQ, OP_START, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd255, 16'd7, REG_MODE, 32'd0, 1'b0, NO_RSP},
        '{ROW_REQ, OP_SAMPLE, 8'd0, 16'd0, REG_MODE, 32'd0, 1'b1,
          '{ST_ZERO_LATENCY, 1'b1, 22'd0, 20'd0, 30'd0, LAT_MAX, 22'd0}}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    ltlt_req_if req_ch ();
    ltlt_rsp_if rsp_ch ();

    light_transition_latency_timer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic               cfg_alt;
    logic [LEVEL_W-1:0] cfg_dark;
    logic [LEVEL_W-1:0] cfg_bright;
    logic [LAT_W-1:0]   cfg_timeout;

    run_phase_t         run_phase;
    logic               run_falling;
    logic               next_falling_dir;
    logic [LAT_W-1:0]   elapsed_us;
    stats_t             tally [2];

    timing_rsp_t        rsp_expected [$];
    int                 mismatches;
    int                 live_items;
    int                 delta_cap;
    bit                 tx_quiet;
    bit                 tx_burst;
    bit                 rx_quiet;
    bit                 hold_rsp;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic bit advance_timer(input logic [OP_W-1:0] op,
                                         input logic [LIGHT_W-1:0] light,
                                         input logic [DELTA_W-1:0] delta,
                                         output timing_rsp_t r);
        logic [LAT_W:0]   sum;
        logic [AVG_W-1:0] target;
        logic [AVG_W-1:0] avg_now;
        logic [CNT_W-1:0] n;
        logic             dark;
        logic             bright;
        logic             s;
        r = '0;
        case (op)
            OP_START:
            begin
                run_falling = cfg_alt ? next_falling_dir : 1'b0;
                run_phase = RUN_SYNC;
                elapsed_us = '0;
                return 1'b0;
            end
            OP_CLEAR:
            begin
                tally[0] = STATS_RESET;
                tally[1] = STATS_RESET;
                next_falling_dir = 1'b0;
                run_phase = RUN_IDLE;
                elapsed_us = '0;
                return 1'b0;
            end
            OP_SAMPLE:
            begin
                if (run_phase == RUN_IDLE)
                    return 1'b0;
            end
            default:
                return 1'b0;
        endcase

        sum = elapsed_us + delta;
        elapsed_us = (sum > LAT_MAX) ? LAT_MAX : sum[LAT_W-1:0];
        dark = light <= cfg_dark;
        bright = light >= cfg_bright;
        s = run_falling;
        r.falling = run_falling;

        if (run_phase == RUN_SYNC)
        begin
            if (run_falling ? bright : dark)
            begin
                run_phase = RUN_TIMING;
                elapsed_us = '0;
                return 1'b0;
            end
            if (elapsed_us <= cfg_timeout)
                return 1'b0;
            run_phase = RUN_IDLE;
            r.status = ST_SYNC_TIMEOUT;
        end
        else if (run_falling ? dark : bright)
        begin
            run_phase = RUN_IDLE;
            if (elapsed_us == '0)
                r.status = ST_ZERO_LATENCY;
            else
            begin
                if (tally[s].cnt != CNT_MAX)
                    tally[s].cnt = tally[s].cnt + 1'b1;
                n = tally[s].cnt;
                tally[s].last = elapsed_us;
                target = {elapsed_us, 8'd0};
                avg_now = tally[s].avg;
                if (target >= avg_now)
                    avg_now = avg_now + (target - avg_now) / n;
                else
                    avg_now = avg_now - (avg_now - target) / n;
                tally[s].avg = avg_now;
                if (elapsed_us < tally[s].min)
                    tally[s].min = elapsed_us;
                if (elapsed_us > tally[s].max)
                    tally[s].max = elapsed_us;
                if (cfg_alt)
                    next_falling_dir = ~run_falling;
                r.status = ST_SUCCESS;
                r.latency = elapsed_us;
            end
        end
        else
        begin
            if (elapsed_us <= cfg_timeout)
                return 1'b0;
            run_phase = RUN_IDLE;
            r.status = ST_TIME_TIMEOUT;
        end

        r.count = tally[s].cnt;
        r.avg = tally[s].avg;
        r.lo = tally[s].min;
        r.hi = tally[s].max;
        return 1'b1;
    endfunction

    function automatic logic [LIGHT_W-1:0] pick_light(input light_kind_t kind);
        case (kind)
            LIT_DARK:
                return 8'($urandom_range(0, cfg_dark));
            LIT_BRIGHT:
                return 8'($urandom_range(cfg_bright, 255));
            LIT_NOT_DARK:
                if (cfg_dark != 8'hFF)
                    return 8'($urandom_range(cfg_dark + 1, 255));
            LIT_NOT_BRIGHT:
                if (cfg_bright != 8'h00)
                    return 8'($urandom_range(0, cfg_bright - 1));
            default:
                ;
        endcase
        return 8'($urandom);
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, delta_cap));
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic [LIGHT_W-1:0] light,
                            input logic [DELTA_W-1:0] delta, input bit known = 1'b0,
                            input timing_rsp_t known_rsp = '0);
        int          gap;
        timing_rsp_t predicted;
        @(negedge clk);
        if ($urandom_range(0, 15) == 0)
            tx_quiet = !tx_quiet;
        gap = (tx_quiet || tx_burst) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.light    <= light;
        req_ch.delta_us <= delta;
        do @(posedge clk); while (!req_ch.ready);
        if (op == OP_START || op == OP_CLEAR || (op == OP_SAMPLE && run_phase != RUN_IDLE))
            live_items++;
        if (advance_timer(op, light, delta, predicted))
            rsp_expected.push_back(known ? known_rsp : predicted);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:    cfg_alt = value[0];
            REG_DARK:    cfg_dark = value[LEVEL_W-1:0];
            REG_BRIGHT:  cfg_bright = value[LEVEL_W-1:0];
            REG_TIMEOUT: cfg_timeout = value[LAT_W-1:0];
            default:     ;
        endcase
    endtask

    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (rsp_expected.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_once(input int sync_miss, input int time_miss, input bit long_steps);
        send_req(OP_START, 8'($urandom), 16'($urandom));
        for (int i = 0; i < sync_miss && run_phase == RUN_SYNC; i++)
            send_req(OP_SAMPLE, pick_light(run_falling ? LIT_NOT_BRIGHT : LIT_NOT_DARK),
                     pick_delta());
        if (run_phase != RUN_SYNC)
            return;
        send_req(OP_SAMPLE, pick_light(run_falling ? LIT_BRIGHT : LIT_DARK), pick_delta());
        for (int i = 0; i < time_miss && run_phase == RUN_TIMING; i++)
            send_req(OP_SAMPLE, pick_light(run_falling ? LIT_NOT_DARK : LIT_NOT_BRIGHT),
                     long_steps ? 16'hFFFF : pick_delta());
        if (run_phase == RUN_TIMING)
            send_req(OP_SAMPLE, pick_light(run_falling ? LIT_DARK : LIT_BRIGHT), pick_delta());
    endtask

    always @(posedge clk)
    begin
        timing_rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (rsp_expected.size() == 0)
            begin
                $display("%0t: response with nothing expected, status %0d", $time,
                         rsp_ch.status);
                mismatches++;
            end
            else
            begin
                want = rsp_expected.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("falling", want.falling, rsp_ch.falling);
                check_field("latency_us", want.latency, rsp_ch.latency_us);
                check_field("run_count", want.count, rsp_ch.run_count);
                check_field("avg_us_q8", want.avg, rsp_ch.avg_us_q8);
                check_field("min_us", want.lo, rsp_ch.min_us);
                check_field("max_us", want.hi, rsp_ch.max_us);
            end
        end
    end

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_rsp = 1'b0;
            end
            if ($urandom_range(0, 15) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [DATA_W-1:0] alt;
        logic [DATA_W-1:0] dark;
        logic [DATA_W-1:0] bright;
        logic [DATA_W-1:0] tmo;
        int                phase_mark;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_START;
        req_ch.light = '0;
        req_ch.delta_us = '0;
        mismatches = 0;
        live_items = 0;
        delta_cap = 1000;
        tx_quiet = 1'b0;
        tx_burst = 1'b0;
        rx_quiet = 1'b0;
        hold_rsp = 1'b0;

        cfg_alt = 1'b0;
        cfg_dark = DARK_RESET;
        cfg_bright = BRIGHT_RESET;
        cfg_timeout = TIMEOUT_RESET;
        run_phase = RUN_IDLE;
        run_falling = 1'b0;
        next_falling_dir = 1'b0;
        elapsed_us = '0;
        tally[0] = STATS_RESET;
        tally[1] = STATS_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
            end
            else
                send_req(PLAN[i].op, PLAN[i].light, PLAN[i].delta, PLAN[i].known,
                         PLAN[i].want);
        end

        for (int ph = 0; ph < 6 || live_items < TARGET_ITEMS; ph++)
        begin
            case (ph)
                0:
                begin
                    alt = 1; dark = 64; bright = 192; tmo = 3000; delta_cap = 1500;
                end
                1:
                begin
                    alt = 0; dark = 0; bright = 255; tmo = 1; delta_cap = 3;
                end
                2:
                begin
                    alt = 1; dark = 255; bright = 0; tmo = 4000000; delta_cap = 65535;
                end
                3:
                begin
                    alt = 1; dark = 100; bright = 150; tmo = LAT_MAX; delta_cap = 65535;
                end
                4:
                begin
                    alt = $urandom_range(0, 1); dark = $urandom_range(0, 255);
                    bright = $urandom_range(0, 255); tmo = 0; delta_cap = 2;
                end
                default:
                begin
                    alt = $urandom_range(0, 1);
                    dark = $urandom_range(0, 255);
                    bright = $urandom_range(0, 255);
                    tmo = $urandom_range(1, 300000);
                    delta_cap = $urandom_range(1, 65535);
                end
            endcase
            settle();
            write_reg(REG_MODE, alt);
            write_reg(REG_DARK, dark);
            write_reg(REG_BRIGHT, bright);
            write_reg(REG_TIMEOUT, tmo);
            phase_mark = live_items;

            // stall the response side while sync timeouts keep coming
            if (ph == 0)
            begin
                hold_rsp = 1'b1;
                tx_burst = 1'b1;
                repeat (6)
                begin
                    send_req(OP_START, 8'($urandom), 16'($urandom));
                    send_req(OP_SAMPLE,
                             pick_light(run_falling ? LIT_NOT_BRIGHT : LIT_NOT_DARK),
                             16'hFFFF);
                end
                tx_burst = 1'b0;
            end
            // long timing runs: timeout near the top, elapsed saturation
            if (ph == 2 || ph == 3)
                run_once(0, 66, 1'b1);

            while (live_items < phase_mark + PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0:
                        send_req(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
                    1:
                    begin
                        send_req(OP_START, 8'($urandom), 16'($urandom));
                        send_req(OP_SAMPLE, 8'($urandom), pick_delta());
                        send_req(($urandom_range(0, 2) == 0) ? OP_CLEAR : OP_START,
                                 8'($urandom), 16'($urandom));
                    end
                    default:
                        run_once($urandom_range(0, 3), $urandom_range(0, 4), 1'b0);
                endcase
            end
        end

        settle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
